// ===== sv/jsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsv_pkg
// shared types, codes and character classes of the json syntax validator
// ----------------------------------------------------------------------------
package jsv_pkg;

    localparam int STACK_DEPTH_DEF = 32;
    localparam logic [5:0] MAX_DEPTH_RST = 6'd32;
    localparam int PADDR_W = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [3:0] error_kind;
        logic [5:0] nest_depth;
    } out_item_t;

    localparam logic [1:0] STATUS_RUN = 2'd0;
    localparam logic [1:0] STATUS_ACCEPT = 2'd1;
    localparam logic [1:0] STATUS_REJECT = 2'd2;

    localparam logic [1:0] FIN_RUN = 2'd0;
    localparam logic [1:0] FIN_DONE = 2'd1;
    localparam logic [1:0] FIN_ERR = 2'd2;

    localparam logic [3:0] ERR_NONE = 4'd0;
    localparam logic [3:0] ERR_EARLY_END = 4'd1;
    localparam logic [3:0] ERR_EXP_END = 4'd2;
    localparam logic [3:0] ERR_VALUE = 4'd3;
    localparam logic [3:0] ERR_ELEM_OR_RBRK = 4'd4;
    localparam logic [3:0] ERR_COMMA_OR_RBRK = 4'd5;
    localparam logic [3:0] ERR_STR_OR_RBRC = 4'd6;
    localparam logic [3:0] ERR_COLON = 4'd7;
    localparam logic [3:0] ERR_COMMA_OR_RBRC = 4'd8;
    localparam logic [3:0] ERR_STRING = 4'd9;
    localparam logic [3:0] ERR_BAD_TOKEN = 4'd10;
    localparam logic [3:0] ERR_RAW_CTRL = 4'd11;
    localparam logic [3:0] ERR_BAD_HEX = 4'd12;
    localparam logic [3:0] ERR_BAD_ESC = 4'd13;
    localparam logic [3:0] ERR_TOO_DEEP = 4'd14;

    localparam logic [PADDR_W-1:0] ADDR_MAX_DEPTH = 3'd0;

    typedef enum logic [2:0] {
        PS_VALUE     = 3'd0,
        PS_ARR_START = 3'd1,
        PS_ARR_NEXT  = 3'd2,
        PS_OBJ_START = 3'd3,
        PS_OBJ_LABEL = 3'd4,
        PS_OBJ_NEXT  = 3'd5,
        PS_OBJ_COMMA = 3'd6
    } ps_t;

    typedef enum logic [3:0] {
        LX_IDLE   = 4'd0,
        LX_STR    = 4'd1,
        LX_ESC    = 4'd2,
        LX_HEX    = 4'd3,
        LX_WORD   = 4'd4,
        LX_NSIGN  = 4'd5,
        LX_NZERO  = 4'd6,
        LX_NINT   = 4'd7,
        LX_NDOT   = 4'd8,
        LX_NFRAC  = 4'd9,
        LX_NEXP   = 4'd10,
        LX_NESIGN = 4'd11,
        LX_NEDIG  = 4'd12,
        LX_NTAIL  = 4'd13,
        LX_DONE   = 4'd14
    } lx_t;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_PUNCT  = 3'd1,
        EV_STRING = 3'd2,
        EV_SCALAR = 3'd3,
        EV_ERR    = 3'd4
    } ev_kind_t;

    typedef enum logic [2:0] {
        PU_LBRK  = 3'd0,
        PU_RBRK  = 3'd1,
        PU_LBRC  = 3'd2,
        PU_RBRC  = 3'd3,
        PU_COMMA = 3'd4,
        PU_COLON = 3'd5
    } punct_t;

    typedef struct packed {
        ev_kind_t   kind;
        punct_t     pu;
        logic [3:0] err;
    } ev_t;

    // one classified byte: an optional token close, then the byte itself
    typedef struct packed {
        ev_t  ev_a;
        ev_t  ev_b;
        logic eod;
    } q_item_t;

    localparam logic [3:0] WM_BAD = 4'd15;

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || is_digit(c) ||
               c == "_" || c[7];
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    // expected next letter of true / null / false, zero at a word end
    function automatic logic [7:0] wm_next(input logic [3:0] w);
        logic [7:0] r;
        begin
            case (w)
                4'd1:    r = "r";
                4'd2:    r = "u";
                4'd3:    r = "e";
                4'd5:    r = "u";
                4'd6:    r = "l";
                4'd7:    r = "l";
                4'd9:    r = "a";
                4'd10:   r = "l";
                4'd11:   r = "s";
                4'd12:   r = "e";
                default: r = 8'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/jsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsv_front
// character lexer: turns each byte into up to two ordered token events
// ----------------------------------------------------------------------------
module jsv_front import jsv_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output q_item_t  q_item
);

    typedef struct packed {
        lx_t  ph;
        logic bad;
    } ns_t;

    lx_t        phase_reg, phase_next;
    logic [1:0] hex_reg, hex_next;
    logic [3:0] wm_reg, wm_next_v;
    logic       bad_reg, bad_next;

    function automatic ns_t after_exp(input logic [7:0] c);
        ns_t r;
        begin
            r.ph = is_alnum(c) ? LX_NTAIL : LX_DONE;
            r.bad = is_alnum(c);
            return r;
        end
    endfunction

    function automatic ns_t after_frac(input logic [7:0] c);
        ns_t r;
        begin
            if (c == "e" || c == "E")
            begin
                r.ph = LX_NEXP;
                r.bad = 1'b0;
            end
            else
                r = after_exp(c);
            return r;
        end
    endfunction

    function automatic ns_t after_int(input logic [7:0] c);
        ns_t r;
        begin
            if (c == ".")
            begin
                r.ph = LX_NDOT;
                r.bad = 1'b0;
            end
            else
                r = after_frac(c);
            return r;
        end
    endfunction

    function automatic ns_t num_step(input lx_t ph, input logic [7:0] c);
        ns_t r;
        begin
            r.ph = LX_DONE;
            r.bad = 1'b0;
            case (ph)
                LX_NSIGN:
                begin
                    if (c == "0") r.ph = LX_NZERO;
                    else if (is_digit(c)) r.ph = LX_NINT;
                    else
                    begin
                        r = after_int(c);
                        r.bad = 1'b1;
                    end
                end
                LX_NZERO: r = after_int(c);
                LX_NINT:
                begin
                    if (is_digit(c)) r.ph = LX_NINT;
                    else r = after_int(c);
                end
                LX_NDOT:
                begin
                    if (is_digit(c)) r.ph = LX_NFRAC;
                    else
                    begin
                        r = after_frac(c);
                        r.bad = 1'b1;
                    end
                end
                LX_NFRAC:
                begin
                    if (is_digit(c)) r.ph = LX_NFRAC;
                    else r = after_frac(c);
                end
                LX_NEXP:
                begin
                    if (c == "+" || c == "-") r.ph = LX_NESIGN;
                    else if (is_digit(c)) r.ph = LX_NEDIG;
                    else
                    begin
                        r = after_exp(c);
                        r.bad = 1'b1;
                    end
                end
                LX_NESIGN:
                begin
                    if (is_digit(c)) r.ph = LX_NEDIG;
                    else
                    begin
                        r = after_exp(c);
                        r.bad = 1'b1;
                    end
                end
                LX_NEDIG:
                begin
                    if (is_digit(c)) r.ph = LX_NEDIG;
                    else r = after_exp(c);
                end
                default: r.ph = is_alnum(c) ? LX_NTAIL : LX_DONE;
            endcase
            return r;
        end
    endfunction

    logic [7:0] c;
    logic       eod;
    logic       do_start;
    ns_t        ns;
    logic       word_ok;

    assign c = item.data_byte;
    assign eod = item.end_of_input || (c == 8'd0);
    assign word_ok = (wm_reg == 4'd4) || (wm_reg == 4'd8) || (wm_reg == 4'd13);

    always_comb
    begin
        phase_next = phase_reg;
        hex_next = hex_reg;
        wm_next_v = wm_reg;
        bad_next = bad_reg;
        q_item.ev_a = '{kind: EV_NONE, pu: PU_LBRK, err: ERR_NONE};
        q_item.ev_b = '{kind: EV_NONE, pu: PU_LBRK, err: ERR_NONE};
        q_item.eod = eod;
        do_start = 1'b0;
        ns = num_step(phase_reg, eod ? 8'd0 : c);
        if (eod)
        begin
            case (phase_reg)
                LX_IDLE: ;
                LX_STR, LX_ESC, LX_HEX:
                    q_item.ev_a = '{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN};
                LX_WORD:
                    q_item.ev_a = word_ok
                        ? ev_t'{kind: EV_SCALAR, pu: PU_LBRK, err: ERR_NONE}
                        : ev_t'{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN};
                default:
                    q_item.ev_a = (bad_reg || ns.bad)
                        ? ev_t'{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN}
                        : ev_t'{kind: EV_SCALAR, pu: PU_LBRK, err: ERR_NONE};
            endcase
            phase_next = LX_IDLE;
            hex_next = 2'd0;
            wm_next_v = 4'd0;
            bad_next = 1'b0;
        end
        else
        begin
            case (phase_reg)
                LX_IDLE: do_start = 1'b1;
                LX_STR:
                begin
                    if (c == "\"")
                    begin
                        phase_next = LX_IDLE;
                        q_item.ev_b = '{kind: EV_STRING, pu: PU_LBRK, err: ERR_NONE};
                    end
                    else if (c < 8'd32)
                        q_item.ev_b = '{kind: EV_ERR, pu: PU_LBRK, err: ERR_RAW_CTRL};
                    else if (c == "\\")
                        phase_next = LX_ESC;
                end
                LX_ESC:
                begin
                    if (c == "u")
                    begin
                        phase_next = LX_HEX;
                        hex_next = 2'd0;
                    end
                    else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                             c == "n" || c == "r" || c == "t")
                        phase_next = LX_STR;
                    else
                        q_item.ev_b = '{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_ESC};
                end
                LX_HEX:
                begin
                    if (!is_hex(c))
                        q_item.ev_b = '{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_HEX};
                    else if (hex_reg == 2'd3)
                    begin
                        hex_next = 2'd0;
                        phase_next = LX_STR;
                    end
                    else
                        hex_next = hex_reg + 2'd1;
                end
                LX_WORD:
                begin
                    if (is_alnum(c))
                        wm_next_v = (wm_next(wm_reg) != 8'd0 && c == wm_next(wm_reg))
                                    ? wm_reg + 4'd1 : WM_BAD;
                    else
                    begin
                        q_item.ev_a = word_ok
                            ? ev_t'{kind: EV_SCALAR, pu: PU_LBRK, err: ERR_NONE}
                            : ev_t'{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN};
                        phase_next = LX_IDLE;
                        wm_next_v = 4'd0;
                        do_start = 1'b1;
                    end
                end
                default:
                begin
                    if (ns.ph != LX_DONE)
                    begin
                        phase_next = ns.ph;
                        bad_next = bad_reg | ns.bad;
                    end
                    else
                    begin
                        q_item.ev_a = (bad_reg || ns.bad)
                            ? ev_t'{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN}
                            : ev_t'{kind: EV_SCALAR, pu: PU_LBRK, err: ERR_NONE};
                        phase_next = LX_IDLE;
                        bad_next = 1'b0;
                        do_start = 1'b1;
                    end
                end
            endcase

            // token start from between tokens
            if (do_start)
            begin
                if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d)
                    ;
                else if (c == "[")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_LBRK, err: ERR_NONE};
                else if (c == "]")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_RBRK, err: ERR_NONE};
                else if (c == "{")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_LBRC, err: ERR_NONE};
                else if (c == "}")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_RBRC, err: ERR_NONE};
                else if (c == ",")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_COMMA, err: ERR_NONE};
                else if (c == ":")
                    q_item.ev_b = '{kind: EV_PUNCT, pu: PU_COLON, err: ERR_NONE};
                else if (c == "\"")
                    phase_next = LX_STR;
                else if (c == "-")
                begin
                    phase_next = LX_NSIGN;
                    bad_next = 1'b0;
                end
                else if (is_digit(c))
                begin
                    phase_next = (c == "0") ? LX_NZERO : LX_NINT;
                    bad_next = 1'b0;
                end
                else if (is_alnum(c))
                begin
                    phase_next = LX_WORD;
                    wm_next_v = (c == "t") ? 4'd1 : (c == "n") ? 4'd5 :
                                (c == "f") ? 4'd9 : WM_BAD;
                end
                else
                    q_item.ev_b = '{kind: EV_ERR, pu: PU_LBRK, err: ERR_BAD_TOKEN};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= LX_IDLE;
            hex_reg <= 2'd0;
            wm_reg <= 4'd0;
            bad_reg <= 1'b0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            hex_reg <= hex_next;
            wm_reg <= wm_next_v;
            bad_reg <= bad_next;
        end
    end

endmodule

// ===== sv/jsv_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsv_queue
// two-entry queue of classified bytes between lexer and parser
// ----------------------------------------------------------------------------
module jsv_queue import jsv_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_item_t push_item,
    input  logic    pop,
    output logic    full,
    output logic    not_empty,
    output q_item_t head
);

    q_item_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign full = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop) rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

// ===== sv/jsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsv_back
// parser: container stack, sticky error and the registered result
// ----------------------------------------------------------------------------
module jsv_back import jsv_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_valid,
    input  q_item_t    q_head,
    output logic       q_pop,
    input  logic [5:0] max_depth,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_data
);

    localparam int LW = $clog2(STACK_DEPTH + 1);
    localparam int NW = $clog2(STACK_DEPTH + 2);
    localparam int CW = ((NW > 6) ? NW : 6) + 1;

    // entries below the top are always "array next" (0) or "object next" (1)
    typedef struct packed {
        logic [LW-1:0]          level;
        logic [STACK_DEPTH-1:0] below;
        ps_t                    top;
        logic [1:0]             fin;
        logic [3:0]             err;
    } st_t;

    localparam st_t ST_RST = '{level: '0, below: '0, top: PS_VALUE, fin: FIN_RUN,
                               err: ERR_NONE};

    st_t st_reg, st_a, st_b, st_next;
    logic      out_valid_reg;
    out_item_t out_data_reg, out_data_next;
    logic [CW-1:0] lim;

    assign lim = (CW'(max_depth) > CW'(STACK_DEPTH)) ? CW'(STACK_DEPTH) : CW'(max_depth);

    function automatic st_t set_err(input st_t s, input logic [3:0] k);
        st_t r;
        begin
            r = s;
            if (s.fin != FIN_ERR)
            begin
                r.err = k;
                r.fin = FIN_ERR;
            end
            return r;
        end
    endfunction

    function automatic logic [NW-1:0] nest_of(input st_t s);
        return NW'(s.level) + NW'(s.top != PS_VALUE);
    endfunction

    function automatic logic open_bad(input st_t s, input logic [CW-1:0] lm);
        return CW'(nest_of(s)) + CW'(1) > lm;
    endfunction

    function automatic st_t pop_entry(input st_t s);
        st_t r;
        begin
            r = s;
            if (s.level == '0)
                r.fin = FIN_DONE;
            else
            begin
                r.level = s.level - LW'(1);
                r.top = s.below[0] ? PS_OBJ_NEXT : PS_ARR_NEXT;
                r.below = s.below >> 1;
            end
            return r;
        end
    endfunction

    function automatic st_t push_entry(input st_t s, input ps_t nt);
        st_t r;
        begin
            r = s;
            if (s.level == LW'(STACK_DEPTH))
                r = set_err(s, ERR_TOO_DEEP);
            else
            begin
                r.level = s.level + LW'(1);
                r.below = {s.below[STACK_DEPTH-2:0], s.top == PS_OBJ_NEXT};
                r.top = nt;
            end
            return r;
        end
    endfunction

    function automatic st_t apply(input st_t s, input ev_t ev, input logic [CW-1:0] lm);
        st_t  r;
        logic punct;
        logic value;
        begin
            r = s;
            punct = ev.kind == EV_PUNCT;
            value = ev.kind == EV_STRING || ev.kind == EV_SCALAR;
            if (ev.kind == EV_ERR)
                r = set_err(s, ev.err);
            else if (ev.kind == EV_NONE || s.fin == FIN_ERR)
                r = s;
            else if (s.fin == FIN_DONE)
                r = set_err(s, ERR_EXP_END);
            else
            begin
                case (s.top)
                    PS_VALUE:
                    begin
                        if (value) r = pop_entry(s);
                        else if (ev.pu == PU_LBRK || ev.pu == PU_LBRC)
                        begin
                            if (open_bad(s, lm)) r = set_err(s, ERR_TOO_DEEP);
                            else r.top = (ev.pu == PU_LBRK) ? PS_ARR_START : PS_OBJ_START;
                        end
                        else r = set_err(s, ERR_VALUE);
                    end
                    PS_ARR_START:
                    begin
                        if (value) r.top = PS_ARR_NEXT;
                        else if (ev.pu == PU_RBRK) r = pop_entry(s);
                        else if (ev.pu == PU_LBRK || ev.pu == PU_LBRC)
                        begin
                            if (open_bad(s, lm)) r = set_err(s, ERR_TOO_DEEP);
                            else
                            begin
                                r.top = PS_ARR_NEXT;
                                r = push_entry(r, (ev.pu == PU_LBRK) ? PS_ARR_START
                                                                     : PS_OBJ_START);
                            end
                        end
                        else r = set_err(s, ERR_ELEM_OR_RBRK);
                    end
                    PS_ARR_NEXT:
                    begin
                        if (punct && ev.pu == PU_RBRK) r = pop_entry(s);
                        else if (punct && ev.pu == PU_COMMA) r = push_entry(s, PS_VALUE);
                        else r = set_err(s, ERR_COMMA_OR_RBRK);
                    end
                    PS_OBJ_START:
                    begin
                        if (ev.kind == EV_STRING) r.top = PS_OBJ_LABEL;
                        else if (punct && ev.pu == PU_RBRC) r = pop_entry(s);
                        else r = set_err(s, ERR_STR_OR_RBRC);
                    end
                    PS_OBJ_LABEL:
                    begin
                        if (punct && ev.pu == PU_COLON)
                        begin
                            r.top = PS_OBJ_NEXT;
                            r = push_entry(r, PS_VALUE);
                        end
                        else r = set_err(s, ERR_COLON);
                    end
                    PS_OBJ_NEXT:
                    begin
                        if (punct && ev.pu == PU_RBRC) r = pop_entry(s);
                        else if (punct && ev.pu == PU_COMMA) r.top = PS_OBJ_COMMA;
                        else r = set_err(s, ERR_COMMA_OR_RBRC);
                    end
                    default:
                    begin
                        if (ev.kind == EV_STRING) r.top = PS_OBJ_LABEL;
                        else r = set_err(s, ERR_STRING);
                    end
                endcase
            end
            return r;
        end
    endfunction

    assign q_pop = q_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        st_a = apply(st_reg, q_head.ev_a, lim);
        st_b = apply(st_a, q_head.ev_b, lim);
        st_next = st_b;
        if (q_head.eod)
        begin
            if (st_b.fin == FIN_RUN)
                st_b = set_err(st_b, ERR_EARLY_END);
            out_data_next.status = (st_b.fin == FIN_ERR) ? STATUS_REJECT : STATUS_ACCEPT;
            out_data_next.nest_depth = 6'd0;
            st_next = ST_RST;
        end
        else
        begin
            out_data_next.status = (st_b.fin == FIN_ERR) ? STATUS_REJECT : STATUS_RUN;
            out_data_next.nest_depth = (st_b.fin == FIN_DONE) ? 6'd0 : 6'(nest_of(st_b));
        end
        out_data_next.error_kind = st_b.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
                st_reg <= st_next;
            if (q_pop)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

// ===== sv/json_syntax_validator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_syntax_validator_core
// streaming json syntax checker, one document byte per transfer
// ----------------------------------------------------------------------------
// Takes one byte per cycle while in_stall is low and returns one result per
// byte: running, accepted or rejected, the first error kind and the current
// nesting depth. A byte of zero or end_of_input closes the document, reports
// the verdict and clears the block for the next document. The lexer sits in
// front, the parser with its container stack sits behind a two-entry queue,
// and the result leaves from an output register; each byte's classified item
// is registered in the queue, then its result in the output register.
// max_depth (byte address 0) limits nesting; it is capped at STACK_DEPTH.
module json_syntax_validator_core import jsv_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    // byte input channel
    input  logic               in_valid,
    output logic               in_stall,
    input  in_item_t           in_data,
    // result channel
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic       in_take;
    logic       q_full, q_not_empty, q_pop;
    q_item_t    q_in, q_head;
    logic [5:0] max_depth_reg;

    // register block: a single six-bit limit
    assign pready = 1'b1;
    assign prdata = (paddr[PADDR_W-1:2] == ADDR_MAX_DEPTH[PADDR_W-1:2])
                    ? {26'd0, max_depth_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_depth_reg <= MAX_DEPTH_RST;
        else if (psel && penable && pwrite && pready &&
                 paddr[PADDR_W-1:2] == ADDR_MAX_DEPTH[PADDR_W-1:2])
            max_depth_reg <= pwdata[5:0];
    end

    // a byte transfer happens whenever a byte is offered and the queue has room
    assign in_stall = q_full;
    assign in_take = in_valid && !in_stall;

    jsv_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (in_take),
        .item   (in_data),
        .q_item (q_in)
    );

    jsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_item (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    jsv_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .max_depth (max_depth_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a rejection always carries an error kind, nothing else does
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.status == STATUS_REJECT) ==
                       (out_data.error_kind != ERR_NONE)))
        else $error("error kind does not match status");

    // an accepted document reports no open containers
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == STATUS_ACCEPT |-> out_data.nest_depth == 6'd0)
        else $error("accepted with open containers");

    // the queue never takes a byte while full
    assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_take)
        else $error("queue overrun");

endmodule

// ===== sim/json_syntax_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_syntax_checker
// watches the byte and result channels, predicts each verdict, compares
// ----------------------------------------------------------------------------
module json_syntax_checker import jsv_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_item_t           in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_item_t          out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 mismatches,
    output int                 pending
);

    localparam int STK = STACK_DEPTH_DEF;

    // next letter of true / null / false per match position
    localparam byte unsigned SPELL [0:15] = '{8'd0, "r", "u", "e", 8'd0, "u", "l", "l",
                                              8'd0, "a", "l", "s", "e", 8'd0, 8'd0, 8'd0};

    ps_t         stk [0:STK];
    int unsigned lvl;
    lx_t         lx;
    int unsigned hexn;
    logic [3:0]  wm;
    bit          tbad;
    logic [3:0]  ferr;
    logic [1:0]  fin;
    logic [5:0]  md;

    out_item_t   verdict_q [$];

    function automatic bit ch_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit ch_word(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || ch_digit(c) ||
               c == "_" || c >= 8'h80;
    endfunction

    function automatic bit ch_hex(input logic [7:0] c);
        return ch_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic void clear_doc();
        for (int i = 0; i <= STK; i++) stk[i] = PS_VALUE;
        lvl = 0;
        lx = LX_IDLE;
        hexn = 0;
        wm = 0;
        tbad = 0;
        ferr = ERR_NONE;
        fin = FIN_RUN;
    endfunction

    function automatic void flag(input logic [3:0] k);
        if (fin != FIN_ERR) begin
            ferr = k;
            fin = FIN_ERR;
        end
    endfunction

    function automatic int unsigned depth_now();
        if (fin == FIN_DONE) return 0;
        return lvl + 1 - ((stk[lvl] == PS_VALUE) ? 1 : 0);
    endfunction

    function automatic bit may_open();
        int unsigned lim;
        lim = (md > STK) ? STK : md;
        if (depth_now() + 1 > lim) begin
            flag(ERR_TOO_DEEP);
            return 0;
        end
        return 1;
    endfunction

    function automatic bit push_slot();
        if (lvl + 1 > STK) begin
            flag(ERR_TOO_DEEP);
            return 0;
        end
        lvl++;
        stk[lvl] = PS_VALUE;
        return 1;
    endfunction

    function automatic void pop_slot();
        if (lvl == 0) fin = FIN_DONE;
        else lvl--;
    endfunction

    // grammar check of one completed token
    function automatic void take_token(input ev_kind_t k, input logic [7:0] c);
        bit p;
        bit v;
        p = (k == EV_PUNCT);
        v = !p;
        if (fin == FIN_ERR) return;
        if (fin == FIN_DONE) begin
            flag(ERR_EXP_END);
            return;
        end
        case (stk[lvl])
            PS_VALUE: begin
                if (v) pop_slot();
                else if (c == "[") begin if (may_open()) stk[lvl] = PS_ARR_START; end
                else if (c == "{") begin if (may_open()) stk[lvl] = PS_OBJ_START; end
                else flag(ERR_VALUE);
            end
            PS_ARR_START: begin
                if (v) stk[lvl] = PS_ARR_NEXT;
                else if (c == "]") pop_slot();
                else if (c == "[" || c == "{") begin
                    if (may_open()) begin
                        stk[lvl] = PS_ARR_NEXT;
                        if (push_slot())
                            stk[lvl] = (c == "[") ? PS_ARR_START : PS_OBJ_START;
                    end
                end
                else flag(ERR_ELEM_OR_RBRK);
            end
            PS_ARR_NEXT: begin
                if (p && c == "]") pop_slot();
                else if (p && c == ",") void'(push_slot());
                else flag(ERR_COMMA_OR_RBRK);
            end
            PS_OBJ_START: begin
                if (k == EV_STRING) stk[lvl] = PS_OBJ_LABEL;
                else if (p && c == "}") pop_slot();
                else flag(ERR_STR_OR_RBRC);
            end
            PS_OBJ_LABEL: begin
                if (p && c == ":") begin
                    stk[lvl] = PS_OBJ_NEXT;
                    void'(push_slot());
                end
                else flag(ERR_COLON);
            end
            PS_OBJ_NEXT: begin
                if (p && c == "}") pop_slot();
                else if (p && c == ",") stk[lvl] = PS_OBJ_COMMA;
                else flag(ERR_COMMA_OR_RBRC);
            end
            default: begin
                if (k == EV_STRING) stk[lvl] = PS_OBJ_LABEL;
                else flag(ERR_STRING);
            end
        endcase
    endfunction

    function automatic lx_t past_exp(input logic [7:0] c);
        if (ch_word(c)) begin
            tbad = 1;
            return LX_NTAIL;
        end
        return LX_DONE;
    endfunction

    function automatic lx_t past_frac(input logic [7:0] c);
        if (c == "e" || c == "E") return LX_NEXP;
        return past_exp(c);
    endfunction

    function automatic lx_t past_int(input logic [7:0] c);
        if (c == ".") return LX_NDOT;
        return past_frac(c);
    endfunction

    function automatic lx_t number_next(input logic [7:0] c);
        case (lx)
            LX_NSIGN: begin
                if (c == "0") return LX_NZERO;
                if (ch_digit(c)) return LX_NINT;
                tbad = 1;
                return past_int(c);
            end
            LX_NZERO: return past_int(c);
            LX_NINT:  return ch_digit(c) ? LX_NINT : past_int(c);
            LX_NDOT: begin
                if (ch_digit(c)) return LX_NFRAC;
                tbad = 1;
                return past_frac(c);
            end
            LX_NFRAC: return ch_digit(c) ? LX_NFRAC : past_frac(c);
            LX_NEXP: begin
                if (c == "+" || c == "-") return LX_NESIGN;
                if (ch_digit(c)) return LX_NEDIG;
                tbad = 1;
                return past_exp(c);
            end
            LX_NESIGN: begin
                if (ch_digit(c)) return LX_NEDIG;
                tbad = 1;
                return past_exp(c);
            end
            LX_NEDIG: return ch_digit(c) ? LX_NEDIG : past_exp(c);
            default:  return ch_word(c) ? LX_NTAIL : LX_DONE;
        endcase
    endfunction

    // finish a number or word; true while no error is pending
    function automatic bit close_scalar();
        bit bad;
        if (lx == LX_WORD) bad = !(wm == 4 || wm == 8 || wm == 13);
        else bad = tbad;
        lx = LX_IDLE;
        wm = 0;
        tbad = 0;
        if (bad) flag(ERR_BAD_TOKEN);
        else take_token(EV_SCALAR, 8'd0);
        return fin != FIN_ERR;
    endfunction

    function automatic void open_token(input logic [7:0] c);
        if (c == " " || c == 8'h09 || c == 8'h0a || c == 8'h0d) return;
        if (c == "{" || c == "}" || c == "[" || c == "]" || c == "," || c == ":")
            take_token(EV_PUNCT, c);
        else if (c == "\"") lx = LX_STR;
        else if (c == "-") begin
            lx = LX_NSIGN;
            tbad = 0;
        end
        else if (ch_digit(c)) begin
            lx = (c == "0") ? LX_NZERO : LX_NINT;
            tbad = 0;
        end
        else if (ch_word(c)) begin
            lx = LX_WORD;
            wm = (c == "t") ? 4'd1 : (c == "n") ? 4'd5 : (c == "f") ? 4'd9 : WM_BAD;
        end
        else flag(ERR_BAD_TOKEN);
    endfunction

    function automatic void scan_byte(input logic [7:0] c);
        lx_t nx;
        case (lx)
            LX_IDLE: open_token(c);
            LX_STR: begin
                if (c == "\"") begin
                    lx = LX_IDLE;
                    take_token(EV_STRING, 8'd0);
                end
                else if (c < 8'd32) flag(ERR_RAW_CTRL);
                else if (c == "\\") lx = LX_ESC;
            end
            LX_ESC: begin
                if (c == "u") begin
                    lx = LX_HEX;
                    hexn = 0;
                end
                else if (c == "\"" || c == "\\" || c == "/" || c == "b" || c == "f" ||
                         c == "n" || c == "r" || c == "t") lx = LX_STR;
                else flag(ERR_BAD_ESC);
            end
            LX_HEX: begin
                if (!ch_hex(c)) flag(ERR_BAD_HEX);
                else if (hexn >= 3) begin
                    hexn = 0;
                    lx = LX_STR;
                end
                else hexn++;
            end
            LX_WORD: begin
                if (ch_word(c))
                    wm = (SPELL[wm] != 0 && c == SPELL[wm]) ? wm + 4'd1 : WM_BAD;
                else if (close_scalar()) open_token(c);
            end
            default: begin
                nx = number_next(c);
                if (nx != LX_DONE) lx = nx;
                else if (close_scalar()) open_token(c);
            end
        endcase
    endfunction

    function automatic void finish_doc();
        if (lx == LX_STR || lx == LX_ESC || lx == LX_HEX) flag(ERR_BAD_TOKEN);
        else if (lx == LX_WORD) void'(close_scalar());
        else if (lx != LX_IDLE) begin
            void'(number_next(8'd0));
            void'(close_scalar());
        end
        if (fin == FIN_RUN) flag(ERR_EARLY_END);
    endfunction

    // expected verdict for one accepted byte
    function automatic out_item_t validate_byte(input in_item_t it);
        out_item_t r;
        if (it.end_of_input || it.data_byte == 8'd0) begin
            if (fin != FIN_ERR) finish_doc();
            r.status = (fin == FIN_ERR) ? STATUS_REJECT : STATUS_ACCEPT;
            r.error_kind = ferr;
            r.nest_depth = 6'd0;
            clear_doc();
        end
        else begin
            if (fin != FIN_ERR) scan_byte(it.data_byte);
            r.status = (fin == FIN_ERR) ? STATUS_REJECT : STATUS_RUN;
            r.error_kind = ferr;
            r.nest_depth = 6'(depth_now());
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        out_item_t want;
        if (!rst_n) begin
            clear_doc();
            md = MAX_DEPTH_RST;
            verdict_q.delete();
            mismatches = 0;
            pending = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (verdict_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h at %0t", out_data, $time);
                end
                else begin
                    want = verdict_q.pop_front();
                    if (want.status !== out_data.status ||
                        want.error_kind !== out_data.error_kind ||
                        want.nest_depth !== out_data.nest_depth) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at %0t: status %0d/%0d kind %0d/%0d depth %0d/%0d",
                                     $time, want.status, out_data.status, want.error_kind,
                                     out_data.error_kind, want.nest_depth,
                                     out_data.nest_depth);
                    end
                end
            end
            if (in_valid && !in_stall)
                verdict_q.push_back(validate_byte(in_data));
            if (psel && penable && pwrite && pready && paddr == ADDR_MAX_DEPTH)
                md = pwdata[5:0];
            pending = verdict_q.size();
        end
    end

endmodule

// ===== sim/tb_json_syntax_validator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_syntax_validator_core
// random and directed json documents through the validator, checked per byte
// ----------------------------------------------------------------------------
// A few short documents cover some error kinds first, then random documents
// are built from a small grammar (nested arrays and objects, numbers, strings
// with escapes, words) and a part of them is corrupted, truncated or given a
// trailing token. The run walks through six depth limits and three idle
// patterns; a separate checker predicts every result and counts mismatches.
module tb_json_syntax_validator_core;
    import jsv_pkg::*;

    localparam int WATCHDOG = 3000;
    localparam int SEG_BYTES = 325;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_item_t           in_data;
    logic               out_valid;
    logic               out_stall;
    out_item_t          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int mismatches;
    int pending;
    int in_count;     // transfers accepted on the byte channel
    int quiet;        // cycles since any transfer
    int send_idle;    // percent of cycles the sender idles
    int stall_pct;    // percent of cycles the receiver stalls
    int hold_left;    // long receiver hold-off still to run
    int sent;

    byte unsigned doc [$];

    json_syntax_validator_core u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    json_syntax_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .pready    (pready),
        .mismatches(mismatches),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // transfer counting and the watchdog, both on the rising edge
    always @(posedge clk) begin
        if (in_valid && !in_stall) in_count <= in_count + 1;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge clk) begin
        if (hold_left > 0) begin
            out_stall = 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall = ($urandom_range(99) < stall_pct);
    end

    // offer one byte; called and returning at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int tgt;
        while ($urandom_range(99) < send_idle) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data.data_byte = b;
        in_data.end_of_input = eoi;
        tgt = in_count + 1;
        do @(negedge clk); while (in_count != tgt);
        sent++;
    endtask

    task automatic put(input string s);
        foreach (s[i]) doc.push_back(s[i]);
    endtask

    task automatic put_ws();
        case ($urandom_range(7))
            0: put(" ");
            1: doc.push_back(8'h09);
            2: doc.push_back(8'h0a);
            3: doc.push_back(8'h0d);
            default: ;
        endcase
    endtask

    task automatic put_number();
        if ($urandom_range(2) == 0) put("-");
        if ($urandom_range(3) == 0) put("0");
        else repeat ($urandom_range(3, 1)) doc.push_back("0" + $urandom_range(9));
        if ($urandom_range(2) == 0) begin
            put(".");
            repeat ($urandom_range(2, 1)) doc.push_back("0" + $urandom_range(9));
        end
        if ($urandom_range(2) == 0) begin
            put($urandom_range(1) ? "e" : "E");
            case ($urandom_range(2))
                0: put("+");
                1: put("-");
                default: ;
            endcase
            repeat ($urandom_range(2, 1)) doc.push_back("0" + $urandom_range(9));
        end
        // malformed tails now and then
        case ($urandom_range(19))
            0: put("x");
            1: put(".");
            2: put("e");
            3: put("_");
            4: doc.push_back(8'hc3);
            default: ;
        endcase
    endtask

    task automatic put_string();
        string hx;
        hx = "0123456789abcdefABCDEF";
        put("\"");
        repeat ($urandom_range(5)) begin
            case ($urandom_range(9))
                0: begin
                    put("\\");
                    case ($urandom_range(8))
                        0: put("\"");
                        1: put("\\");
                        2: put("/");
                        3: put("b");
                        4: put("f");
                        5: put("n");
                        6: put("r");
                        7: put("t");
                        default: put("q");
                    endcase
                end
                1: begin
                    put("\\u");
                    repeat (4) doc.push_back(hx[$urandom_range(21)]);
                    if ($urandom_range(9) == 0) doc[doc.size() - 1] = "g";
                end
                2: doc.push_back($urandom_range(255, 128));
                3: if ($urandom_range(9) == 0) doc.push_back($urandom_range(31, 1));
                default: doc.push_back($urandom_range(126, 32) == 8'h5c ? 8'h41
                                                                      : $urandom_range(126, 32));
            endcase
        end
        put("\"");
    endtask

    task automatic put_word();
        case ($urandom_range(5))
            0: put("true");
            1: put("false");
            2: put("null");
            3: put("tru");
            4: put("nulll");
            default: put("fAlse");
        endcase
    endtask

    task automatic put_value(input int lvl);
        int r;
        int n;
        r = $urandom_range(9);
        put_ws();
        if (lvl < 4 && r < 3) begin
            put("[");
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
                if (i) put(",");
                put_value(lvl + 1);
            end
            put_ws();
            put("]");
        end
        else if (lvl < 4 && r < 5) begin
            put("{");
            n = $urandom_range(3);
            for (int i = 0; i < n; i++) begin
                if (i) put(",");
                put_ws();
                put_string();
                put_ws();
                put(":");
                put_value(lvl + 1);
            end
            put("}");
        end
        else if (r < 7) put_number();
        else if (r < 8) put_string();
        else put_word();
        put_ws();
    endtask

    // one random document, well formed most of the time
    task automatic make_doc();
        int n;
        doc.delete();
        if ($urandom_range(14) == 0) begin
            n = $urandom_range(35, 28);
            repeat (n) put($urandom_range(1) ? "[" : "[");
            put("1");
            repeat (n) put("]");
        end
        else if ($urandom_range(3) == 0) begin
            // nested object and array mix to reach inner container states
            n = $urandom_range(6, 1);
            repeat (n) put("{\"k\":[");
            put_value(3);
            repeat (n) put("]}");
        end
        else
            put_value(0);
        case ($urandom_range(19))
            0: doc[$urandom_range(doc.size() - 1)] = $urandom_range(255, 1);
            1: doc[$urandom_range(doc.size() - 1)] = $urandom_range(255);
            2: if (doc.size() > 1) doc = doc[0:$urandom_range(doc.size() - 2)];
            3: put_value(1);
            4: put(",");
            default: ;
        endcase
    endtask

    task automatic send_doc();
        foreach (doc[i]) send_byte(doc[i], 1'b0);
        if ($urandom_range(1)) send_byte($urandom_range(255), 1'b1);
        else send_byte(8'd0, 1'b0);
    endtask

    task automatic send_text(input string s);
        doc.delete();
        put(s);
        foreach (doc[i]) send_byte(doc[i], 1'b0);
        send_byte(8'hff, 1'b1);
    endtask

    // register write once the block has drained
    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [31:0] v);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = a;
        pwdata = v;
        penable = 1'b0;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        int unsigned limits [0:5];
        limits = '{32, 1, 0, 63, 5, 2};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_count = 0;
        quiet = 0;
        hold_left = 0;
        sent = 0;
        send_idle = 13;
        stall_pct = 55;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // short documents: bad escape, raw control, bad word, bad number,
        // stray close, then a clean one ended by a zero byte
        send_text("\"\\q");
        send_text("\"\001");
        send_text("tru");
        send_text("1x");
        send_text("}");
        doc.delete();
        put("[-0.5e+3]");
        foreach (doc[i]) send_byte(doc[i], 1'b0);
        send_byte(8'd0, 1'b0);

        for (int seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle = 55;
                stall_pct = 13;
            end
            else if (seg == 4) begin
                send_idle = 0;
                stall_pct = 0;
            end
            write_reg(ADDR_MAX_DEPTH, limits[seg]);
            @(negedge clk);
            if (seg == 4) hold_left = 300;
            while (sent < (seg + 1) * SEG_BYTES) begin
                make_doc();
                send_doc();
            end
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
